[rtl/fbpa_pkg.sv]
package fbpa_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int ADDR_WIDTH_DEF = 32;

    // Fixed field widths.
    localparam int ADDR_W    = 32;
    localparam int BLK_W     = 17;
    localparam int CNT_W     = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES    = 3'd3;

    // Configuration reset values.
    localparam logic [ADDR_W-1:0] POOL_BASE_RST     = 32'd0;
    localparam logic [BLK_W-1:0]  BLOCK_BYTES_RST   = 17'd64;
    localparam logic [CNT_W-1:0]  BLOCKS_IN_USE_RST = 9'd256;
    localparam logic [ADDR_W-1:0] POOL_BYTES_RST    = 32'd16384;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] address;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] block_address;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] quotient;
        logic [BLK_W-1:0]  remainder;
    } t_div_res;

endpackage

[rtl/fbpa_div.sv]
module fbpa_div
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    input  logic [BLK_W-1:0]  i_divisor,
    output logic              o_done,
    output t_div_res          o_res
);

    localparam int STEP_W = $clog2(ADDR_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [ADDR_W-1:0] r_quo;
    logic [BLK_W-1:0]  r_rem;
    logic [BLK_W-1:0]  r_dvs;

    logic [BLK_W:0]   n_shifted;
    logic [BLK_W:0]   n_diff;
    logic             n_qbit;
    logic [BLK_W-1:0] n_rem;

    // Restoring division, one quotient bit per cycle. The dividend is
    // shifted out of the top of r_quo while quotient bits enter at the bottom.
    always_comb begin
        n_shifted = {r_rem, r_quo[ADDR_W-1]};
        n_diff    = n_shifted - {1'b0, r_dvs};
        n_qbit    = (n_shifted >= {1'b0, r_dvs});
        n_rem     = n_qbit ? n_diff[BLK_W-1:0] : n_shifted[BLK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= STEP_W'(ADDR_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo  <= {r_quo[ADDR_W-2:0], n_qbit};
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - STEP_W'(1);
                r_done <= (r_cnt == STEP_W'(1));
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done          = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider restarted while busy");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

endmodule

[rtl/fixed_block_pool_allocator_core.sv]
// Fixed-size block pool allocator with a LIFO free list held in one
// synchronous link memory of MAX_BLOCKS entries. An allocate item pops the
// head block: the head's link is read on acceptance and the result is built
// in S_ALLOC, or at once as out of memory when the list is empty. A release
// item is checked against the pool bounds and block alignment and pushed
// back: S_CHECK and S_RANGE make the bound checks, then the 32-step
// bit-serial divider finds the block index and the alignment remainder; an
// address that already fails the bound checks skips the division. One item
// is processed at a time; the next item can be accepted in the cycle after
// a result enters the output register, where the result waits while the
// next item is accepted. After reset and after every write to a defined
// configuration register the free list is rebuilt in block order by a
// sweep over all MAX_BLOCKS link entries, one link entry per cycle, during
// which no item is accepted. Status codes: 0 ok, 1 out of memory, 2 invalid
// address; the returned block address is zero on every failure and release.
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int IDX_W = AW + 1;
    localparam int PRD_W = AW + BLK_W;
    localparam logic [IDX_W-1:0] LIST_END = IDX_W'(MAX_BLOCKS);
    localparam logic [AW-1:0]    LAST_IDX = AW'(MAX_BLOCKS - 1);
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_WIDTH >= ADDR_W) ? {ADDR_W{1'b1}} :
        ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_CHECK,
        S_RANGE,
        S_DIV,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_sweep;
    logic [IDX_W-1:0]  r_head;

    logic [ADDR_W-1:0] r_pool_base;
    logic [BLK_W-1:0]  r_block_bytes;
    logic [CNT_W-1:0]  r_blocks_in_use;
    logic [ADDR_W-1:0] r_pool_bytes;

    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_offset;
    logic [PRD_W-1:0]  r_prod;
    t_status           r_res_status;
    logic [ADDR_W-1:0] r_res_addr;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [IDX_W-1:0]  r_link [MAX_BLOCKS];
    logic [IDX_W-1:0]  r_rd_data;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [IDX_W-1:0]  mem_wdata;
    logic              mem_re;

    logic [IDX_W-1:0]  eff_count;
    logic [IDX_W-1:0]  sweep_next;
    logic              in_accept;
    logic              cfg_hit;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    t_div_res          div_res;
    logic              rel_ok;
    logic [ADDR_W-1:0] alloc_addr;

    // Counts above the memory depth saturate to it.
    assign eff_count = (32'(r_blocks_in_use) > 32'(MAX_BLOCKS)) ? IDX_W'(MAX_BLOCKS) :
                                                                 IDX_W'(r_blocks_in_use);
    assign sweep_next = IDX_W'(r_sweep) + IDX_W'(1);

    assign in_accept = i_in_valid && o_in_ready;
    assign cfg_hit   = i_cfg_we && (i_cfg_index == CFG_POOL_BASE ||
                                    i_cfg_index == CFG_BLOCK_BYTES ||
                                    i_cfg_index == CFG_BLOCKS_IN_USE ||
                                    i_cfg_index == CFG_POOL_BYTES);
    assign out_free  = !r_out_valid || i_out_ready;
    assign div_start = (r_state == S_RANGE) && (r_offset < r_pool_bytes) &&
                       (r_block_bytes != '0);
    assign rel_ok    = (div_res.remainder == '0) &&
                       (div_res.quotient < ADDR_W'(eff_count));
    assign alloc_addr = (r_pool_base + ADDR_W'(r_prod)) & ADDR_MASK;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep;
        mem_wdata = (sweep_next < eff_count) ? sweep_next : LIST_END;
        if (r_state == S_INIT) begin
            mem_we = 1'b1;
        end else if (r_state == S_DIV && div_done && rel_ok) begin
            mem_we    = 1'b1;
            mem_waddr = div_res.quotient[AW-1:0];
            mem_wdata = r_head;
        end
    end

    assign mem_re = in_accept && (i_in_item.cmd == CMD_ALLOC) && (r_head != LIST_END);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_link[r_head[AW-1:0]];
        end
    end

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_offset),
        .i_divisor  (r_block_bytes),
        .o_done     (div_done),
        .o_res      (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_INIT;
            r_sweep         <= '0;
            r_head          <= LIST_END;
            r_out_valid     <= 1'b0;
            r_pool_base     <= POOL_BASE_RST;
            r_block_bytes   <= BLOCK_BYTES_RST;
            r_blocks_in_use <= BLOCKS_IN_USE_RST;
            r_pool_bytes    <= POOL_BYTES_RST;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out.status        <= r_res_status;
                r_out.block_address <= r_res_addr;
                r_out_valid         <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // A write to a defined configuration register restarts the rebuild of the free list.
            if (cfg_hit) begin
                r_sweep <= '0;
                r_state <= S_INIT;
            end else begin
                unique case (r_state)
                    S_INIT: begin
                        r_sweep <= r_sweep + AW'(1);
                        if (r_sweep == LAST_IDX) begin
                            r_head  <= (eff_count != '0) ? '0 : LIST_END;
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (in_accept) begin
                            r_addr <= i_in_item.address;
                            r_prod <= PRD_W'(r_head[AW-1:0]) * PRD_W'(r_block_bytes);
                            if (i_in_item.cmd == CMD_RELEASE) begin
                                r_state <= S_CHECK;
                            end else if (r_head == LIST_END) begin
                                r_res_status <= ST_OOM;
                                r_res_addr   <= '0;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_ALLOC;
                            end
                        end
                    end
                    S_ALLOC: begin
                        r_head       <= r_rd_data;
                        r_res_status <= ST_OK;
                        r_res_addr   <= alloc_addr;
                        r_state      <= S_DONE;
                    end
                    S_CHECK: begin
                        r_offset   <= r_addr - r_pool_base;
                        r_res_addr <= '0;
                        if (r_addr == '0 || r_addr < r_pool_base) begin
                            r_res_status <= ST_INVALID;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_RANGE;
                        end
                    end
                    S_RANGE: begin
                        if (div_start) begin
                            r_state <= S_DIV;
                        end else begin
                            r_res_status <= ST_INVALID;
                            r_state      <= S_DONE;
                        end
                    end
                    S_DIV: begin
                        if (div_done) begin
                            if (rel_ok) begin
                                r_head       <= IDX_W'(div_res.quotient[AW-1:0]);
                                r_res_status <= ST_OK;
                            end else begin
                                r_res_status <= ST_INVALID;
                            end
                            r_state <= S_DONE;
                        end
                    end
                    S_DONE: begin
                        if (out_free) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_INIT;
                    end
                endcase
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POOL_BASE:     r_pool_base     <= i_cfg_wdata[ADDR_W-1:0];
                    CFG_BLOCK_BYTES:   r_block_bytes   <= i_cfg_wdata[BLK_W-1:0];
                    CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_wdata[CNT_W-1:0];
                    CFG_POOL_BYTES:    r_pool_bytes    <= i_cfg_wdata[ADDR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_mem_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("link memory read and written in the same cycle");

    a_head_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> (r_head < eff_count || r_head == LIST_END))
        else $error("free list head outside the pool");

    a_alloc_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLOC) |-> $past(mem_re))
        else $error("allocate step without a link read");

    a_cfg_rebuilds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_state == S_INIT && !o_in_ready))
        else $error("register write did not start a rebuild");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_block_bytes != '0))
        else $error("division started with zero block size");

endmodule

[tb/fixed_block_pool_allocator_core_tb.sv]
module fixed_block_pool_allocator_core_tb;
    import fbpa_pkg::*;

    localparam int POOL_DEPTH = MAX_BLOCKS_DEF;
    localparam logic [CNT_W-1:0] LIST_END = 9'(MAX_BLOCKS_DEF);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_POOL_BYTES + 3'd1;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_PHASES = 12;
    localparam int ITEMS_PER_HALF = 55;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 o_in_ready;
    t_in_item             in_item;
    logic                 o_out_valid;
    logic                 out_ready;
    t_out_item            o_out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    fixed_block_pool_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // Shadow of the pool configuration and of the free list.
    logic [ADDR_W-1:0] m_base;
    logic [BLK_W-1:0]  m_bsize;
    logic [CNT_W-1:0]  m_count;
    logic [ADDR_W-1:0] m_pbytes;
    logic [CNT_W-1:0]  m_head;
    logic [CNT_W-1:0]  m_link [0:POOL_DEPTH-1];

    t_in_item  pending_cmds[$];
    t_out_item expected_results[$];
    int        items_in_flight = 0;
    int        mismatches = 0;

    // Stimulus-side guess of the free stack, used only to pick releases.
    int free_guess[$];
    int taken_guess[$];

    logic     in_taken = 1'b0;
    int       burst_left = 1;
    int       gap_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_tick = 0;
    int       idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] usable_blocks();
        return (m_count > 9'(POOL_DEPTH)) ? 9'(POOL_DEPTH) : m_count;
    endfunction

    function automatic logic [ADDR_W-1:0] pool_addr(int k);
        logic [63:0] wide;
        wide = 64'(m_base) + 64'(k) * 64'(m_bsize);
        return wide[ADDR_W-1:0];
    endfunction

    function automatic void rebuild_free_list();
        int cnt;
        cnt = int'(usable_blocks());
        for (int i = 0; i < POOL_DEPTH; i++) begin
            m_link[i] = (i + 1 < cnt) ? 9'(i + 1) : LIST_END;
        end
        m_head = (cnt > 0) ? '0 : LIST_END;
    endfunction

    function automatic void apply_pool_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_POOL_BASE: begin
                m_base = data;
                rebuild_free_list();
            end
            CFG_BLOCK_BYTES: begin
                m_bsize = data[BLK_W-1:0];
                rebuild_free_list();
            end
            CFG_BLOCKS_IN_USE: begin
                m_count = data[CNT_W-1:0];
                rebuild_free_list();
            end
            CFG_POOL_BYTES: begin
                m_pbytes = data;
                rebuild_free_list();
            end
            default: ;
        endcase
    endfunction

    // Works out the answer to one command and updates the shadow free list.
    function automatic t_out_item next_pool_result(t_in_item it);
        t_out_item         res;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] idx;
        res.status = ST_OK;
        res.block_address = '0;
        if (it.cmd == CMD_ALLOC) begin
            if (m_head >= LIST_END) begin
                res.status = ST_OOM;
            end else begin
                res.block_address = pool_addr(int'(m_head));
                m_head = m_link[m_head[7:0]];
            end
        end else if (it.address == '0 || it.address < m_base) begin
            res.status = ST_INVALID;
        end else begin
            offset = it.address - m_base;
            if (offset >= m_pbytes || m_bsize == '0 || (offset % 32'(m_bsize)) != '0) begin
                res.status = ST_INVALID;
            end else begin
                idx = offset / 32'(m_bsize);
                if (idx >= 32'(usable_blocks())) begin
                    res.status = ST_INVALID;
                end else begin
                    m_link[idx[7:0]] = m_head;
                    m_head = idx[CNT_W-1:0];
                end
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task automatic queue_cmd(logic cmd, logic [ADDR_W-1:0] a);
        t_in_item it;
        it.cmd = cmd;
        it.address = a;
        pending_cmds.push_back(it);
        items_in_flight++;
    endtask

    // Called at a falling edge; the write strobe is low again when the task returns.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Narrow registers get random junk above their width, which must be dropped.
    task automatic setup_pool(logic [ADDR_W-1:0] base, logic [BLK_W-1:0] bs,
                              logic [CNT_W-1:0] cnt, logic [ADDR_W-1:0] pb);
        logic [CFG_W-1:0] junk;
        junk = $urandom();
        write_cfg(CFG_POOL_BASE, base);
        write_cfg(CFG_BLOCK_BYTES, {junk[CFG_W-1:BLK_W], bs});
        write_cfg(CFG_BLOCKS_IN_USE, {junk[CFG_W-1:CNT_W], cnt});
        write_cfg(CFG_POOL_BYTES, pb);
    endtask

    task automatic wait_idle();
        while (items_in_flight != 0) @(negedge i_clk);
    endtask

    // Mostly allocate/release traffic on blocks believed to be handed out,
    // with a share of malformed releases mixed in.
    task automatic queue_random(int n, int alloc_pct);
        int r;
        int j;
        int k;
        int bs;
        bs = int'(m_bsize);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct || (r < 80 && taken_guess.size() == 0)) begin
                if (free_guess.size() != 0) taken_guess.push_back(free_guess.pop_front());
                queue_cmd(CMD_ALLOC, $urandom());
            end else if (r < 80) begin
                j = $urandom_range(0, taken_guess.size() - 1);
                k = taken_guess[j];
                taken_guess.delete(j);
                free_guess.push_front(k);
                queue_cmd(CMD_RELEASE, pool_addr(k));
            end else begin
                case ($urandom_range(0, 6))
                    0: queue_cmd(CMD_RELEASE, '0);
                    1: queue_cmd(CMD_RELEASE, $urandom());
                    2: queue_cmd(CMD_RELEASE, m_base - 32'd1);
                    3: queue_cmd(CMD_RELEASE, pool_addr($urandom_range(0, POOL_DEPTH - 1))
                                 + 32'($urandom_range(1, (bs > 1) ? bs - 1 : 1)));
                    4: queue_cmd(CMD_RELEASE, m_base + m_pbytes + 32'($urandom_range(0, 3)));
                    5: queue_cmd(CMD_RELEASE, pool_addr(int'(usable_blocks())));
                    // A block that may already be free goes back on the list again.
                    default: queue_cmd(CMD_RELEASE, pool_addr($urandom_range(0, POOL_DEPTH - 1)));
                endcase
            end
        end
    endtask

    // Sender: bursts of items separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            in_valid <= 1'b1;
        end else if (gap_left != 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_cmds.size() != 0) begin
            in_valid <= 1'b1;
            in_item <= pending_cmds.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 16);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: its own stall pattern, switched every so often.
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 97 == 0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= (rx_tick % 8 == 0);
            default:   out_ready <= (rx_tick % 5 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item exp_item;
        in_taken <= in_valid && o_in_ready;
        if (i_rst_n) begin
            if (cfg_we) apply_pool_cfg(cfg_index, cfg_wdata);
            if (in_valid && o_in_ready) expected_results.push_back(next_pool_result(in_item));
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch($sformatf("result status=%0d addr=%h with nothing expected",
                                            o_out_item.status, o_out_item.block_address));
                end else begin
                    exp_item = expected_results.pop_front();
                    items_in_flight--;
                    if (o_out_item.status != exp_item.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                o_out_item.status, exp_item.status));
                    if (o_out_item.block_address != exp_item.block_address)
                        flag_mismatch($sformatf("block_address %h, expected %h",
                                                o_out_item.block_address,
                                                exp_item.block_address));
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [ADDR_W-1:0] base;
        logic [BLK_W-1:0]  bs;
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] pb;
        int                pct;

        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        m_base = POOL_BASE_RST;
        m_bsize = BLOCK_BYTES_RST;
        m_count = BLOCKS_IN_USE_RST;
        m_pbytes = POOL_BYTES_RST;
        rebuild_free_list();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: base 0, 64-byte blocks, 256 blocks, 16 KiB.
        queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
        queue_cmd(CMD_ALLOC, '0);
        queue_cmd(CMD_RELEASE, 32'd64);
        queue_cmd(CMD_RELEASE, 32'd0);
        queue_cmd(CMD_RELEASE, 32'd63);
        queue_cmd(CMD_RELEASE, 32'd16384);
        queue_cmd(CMD_RELEASE, 32'hFFFF_FFFF);
        queue_cmd(CMD_RELEASE, 32'd16320);
        queue_cmd(CMD_ALLOC, $urandom());
        queue_cmd(CMD_ALLOC, $urandom());
        queue_cmd(CMD_ALLOC, $urandom());
        wait_idle();

        // Four-block pool with room left over, so the past-count check is reachable.
        setup_pool(32'h100, 17'd64, 9'd4, 32'd1024);
        repeat (5) queue_cmd(CMD_ALLOC, $urandom());
        queue_cmd(CMD_RELEASE, 32'h200);
        queue_cmd(CMD_RELEASE, 32'hFF);
        queue_cmd(CMD_RELEASE, 32'h500);
        queue_cmd(CMD_RELEASE, 32'h141);
        queue_cmd(CMD_RELEASE, 32'h180);
        queue_cmd(CMD_RELEASE, 32'h100);
        repeat (3) queue_cmd(CMD_ALLOC, $urandom());
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    base = 32'h1000; bs = 17'd4; cnt = 9'd1; pb = 32'd4;
                end
                1: begin
                    base = 32'hFFFF_0000; bs = 17'h10000; cnt = 9'd2; pb = 32'hFFFF_FFFF;
                end
                2: begin
                    base = '0; bs = '0; cnt = 9'd5; pb = 32'd1000;
                end
                3: begin
                    base = $urandom(); bs = 17'd64; cnt = '0; pb = 32'hFFFF_FFFF;
                end
                4: begin
                    base = 32'h8000_0000; bs = 17'd64; cnt = 9'd300; pb = 32'hFFFF_FFFF;
                end
                5: begin
                    base = 32'hFFFF_FFFF; bs = 17'($urandom_range(4, 65536));
                    cnt = 9'd511; pb = '0;
                end
                6: begin
                    base = 32'h100; bs = 17'd16; cnt = 9'd256; pb = 32'd4096;
                end
                default: begin
                    base = ($urandom_range(0, 1) != 0) ? $urandom() : 32'($urandom_range(0, 4095));
                    bs = ($urandom_range(0, 1) != 0) ? 17'(1 << $urandom_range(2, 16))
                                                     : 17'($urandom_range(4, 65536));
                    cnt = ($urandom_range(0, 1) != 0) ? 9'($urandom_range(1, 16))
                                                      : 9'($urandom_range(1, 256));
                    pb = ($urandom_range(0, 1) != 0) ? 32'(cnt) * 32'(bs) : $urandom();
                end
            endcase
            setup_pool(base, bs, cnt, pb);
            free_guess.delete();
            taken_guess.delete();
            for (int i = 0; i < int'(usable_blocks()); i++) free_guess.push_back(i);
            pct = $urandom_range(30, 60);
            queue_random(ITEMS_PER_HALF, pct);
            wait_idle();
            // An undefined index must leave the free list as it is.
            write_cfg(CFG_FIRST_UNUSED + 3'($urandom_range(0, 3)), $urandom());
            queue_random(ITEMS_PER_HALF, pct);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
